@@ hw/rtl/lfu_pkg.sv @@
// shared types and constants for the lfu cache with lru tie-break
package lfu_pkg;

    // number of slots and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIVE_W   = $clog2(CAPACITY + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (LIVE_W > CAP_W) ? LIVE_W : CAP_W;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int STAMP_W  = 64;

    // register reset value and fixed codes
    localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
    localparam logic               OP_GET     = 1'b0;
    localparam logic               OP_PUT     = 1'b1;
    localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
    localparam logic [COUNT_W-1:0] FIRST_USE  = COUNT_W'(1);

    // one request
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } lfu_req_t;

    // one result
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } lfu_rsp_t;

    // slot compare outcome
    typedef struct packed {
        logic key_eq;
        logic beats_best;
    } lfu_cmp_t;

endpackage

@@ hw/rtl/lfu_slot_cmp.sv @@
// shared compare unit: key match and lfu/lru victim ordering for one slot
module lfu_slot_cmp (
    input  logic [lfu_pkg::DATA_W-1:0]  slot_key,
    input  logic [lfu_pkg::DATA_W-1:0]  req_key,
    input  logic [lfu_pkg::COUNT_W-1:0] slot_count,
    input  logic [lfu_pkg::STAMP_W-1:0] slot_stamp,
    input  logic                        best_valid,
    input  logic [lfu_pkg::COUNT_W-1:0] best_count,
    input  logic [lfu_pkg::STAMP_W-1:0] best_stamp,
    output lfu_pkg::lfu_cmp_t           cmp
);
    import lfu_pkg::*;

    // raw bit pattern key match
    assign cmp.key_eq = (slot_key == req_key);

    // lower count wins, then older stamp
    assign cmp.beats_best = !best_valid
                         || (slot_count < best_count)
                         || ((slot_count == best_count) && (slot_stamp < best_stamp));

endmodule

@@ hw/rtl/lfu_cache_with_lru_tiebreak.sv @@
// top level of the lfu cache with lru tie-break: sequencer, slot store and result register
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------------
//  request   | start, busy, req           | taken when start high and busy low
//  result    | done, rsp                  | one-cycle strobe, cannot be held off
//  config    | cfg_we, cfg_wdata          | written when cfg_we high, no wait
//
//  each request runs through scan and update before the next possible accept; the
//  result strobe comes on the cycle busy drops
//  the request time is set by the one compare unit walking the 16 slots one per cycle
//  behind the registered slot read, followed by the write back step
//  reset clears valid bits, entry count and touch clock, and sets capacity to 16
//  the result side cannot stall; requests wait on busy
module lfu_cache_with_lru_tiebreak (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lfu_pkg::lfu_req_t         req,
    output logic                      done,
    output lfu_pkg::lfu_rsp_t         rsp,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
    import lfu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } state_t;

    // slot store, no reset
    logic [DATA_W-1:0]  slot_key_mem   [CAPACITY];
    logic [DATA_W-1:0]  slot_value_mem [CAPACITY];
    logic [COUNT_W-1:0] slot_count_mem [CAPACITY];
    logic [STAMP_W-1:0] slot_stamp_mem [CAPACITY];

    // registered slot read
    logic [DATA_W-1:0]  rd_key_reg;
    logic [DATA_W-1:0]  rd_value_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    // control and scan state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_on_reg, rd_on_next;
    logic               rd_valid_reg, rd_valid_next;
    lfu_req_t           req_reg, req_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [DATA_W-1:0]  found_value_reg, found_value_next;
    logic [COUNT_W-1:0] found_count_reg, found_count_next;
    logic               vict_reg, vict_next;
    logic [IDX_W-1:0]   vict_idx_reg, vict_idx_next;
    logic [DATA_W-1:0]  vict_key_reg, vict_key_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [LIVE_W-1:0]  live_reg, live_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    lfu_rsp_t           rsp_reg, rsp_next;
    logic               done_reg, done_next;

    // store write port
    logic               wr_en;
    logic               wr_key_en;
    logic               wr_value_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [DATA_W-1:0]  wr_key;
    logic [DATA_W-1:0]  wr_value;
    logic [COUNT_W-1:0] wr_count;
    logic [STAMP_W-1:0] wr_stamp;

    lfu_cmp_t           cmp;
    logic               full;

    // shared compare unit
    lfu_slot_cmp u_cmp (
        .slot_key   (rd_key_reg),
        .req_key    (req_reg.key),
        .slot_count (rd_count_reg),
        .slot_stamp (rd_stamp_reg),
        .best_valid (vict_reg),
        .best_count (best_count_reg),
        .best_stamp (best_stamp_reg),
        .cmp        (cmp)
    );

    // store full for this put: capacity reached or no free slot
    assign full = (CMP_W'(live_reg) >= CMP_W'(cap_reg)) || !free_reg;

    // sequencer and update decision
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        rd_idx_next      = idx_reg;
        rd_on_next       = 1'b0;
        rd_valid_next    = valid_reg[idx_reg];
        req_next         = req_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        found_value_next = found_value_reg;
        found_count_next = found_count_reg;
        vict_next        = vict_reg;
        vict_idx_next    = vict_idx_reg;
        vict_key_next    = vict_key_reg;
        best_count_next  = best_count_reg;
        best_stamp_next  = best_stamp_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        live_next        = live_reg;
        clock_next       = clock_reg;
        cap_next         = cfg_we ? cfg_wdata : cap_reg;
        valid_next       = valid_reg;
        rsp_next         = rsp_reg;
        done_next        = 1'b0;
        wr_en            = 1'b0;
        wr_key_en        = 1'b0;
        wr_value_en      = 1'b0;
        wr_idx           = found_idx_reg;
        wr_key           = req_reg.key;
        wr_value         = req_reg.value;
        wr_count         = (found_count_reg == '1) ? found_count_reg
                                                   : found_count_reg + COUNT_W'(1);
        wr_stamp         = clock_reg;

        // compare stage on the slot read last cycle
        if (rd_on_reg)
        begin
            if (rd_valid_reg)
            begin
                if (!found_reg && cmp.key_eq)
                begin
                    found_next       = 1'b1;
                    found_idx_next   = rd_idx_reg;
                    found_value_next = rd_value_reg;
                    found_count_next = rd_count_reg;
                end
                if (cmp.beats_best)
                begin
                    vict_next       = 1'b1;
                    vict_idx_next   = rd_idx_reg;
                    vict_key_next   = rd_key_reg;
                    best_count_next = rd_count_reg;
                    best_stamp_next = rd_stamp_reg;
                end
            end
            else if (!free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    found_next = 1'b0;
                    vict_next  = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_on_next = 1'b1;
                if (idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                rsp_next   = '0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (req_reg.op == OP_GET)
                begin
                    if (found_reg)
                    begin
                        // get hit: bump count and stamp
                        rsp_next.hit        = 1'b1;
                        rsp_next.read_value = found_value_reg;
                        wr_en               = 1'b1;
                        clock_next          = clock_reg + STAMP_W'(1);
                    end
                    else
                    begin
                        rsp_next.read_value = MISS_VALUE;
                    end
                end
                else if (cap_reg != '0)
                begin
                    if (found_reg)
                    begin
                        // put hit: new value, bump count and stamp
                        rsp_next.hit = 1'b1;
                        wr_en        = 1'b1;
                        wr_value_en  = 1'b1;
                        clock_next   = clock_reg + STAMP_W'(1);
                    end
                    else if (!full || vict_reg)
                    begin
                        // put miss: fill a free slot or replace the victim
                        wr_en       = 1'b1;
                        wr_key_en   = 1'b1;
                        wr_value_en = 1'b1;
                        wr_count    = FIRST_USE;
                        clock_next  = clock_reg + STAMP_W'(1);
                        if (full)
                        begin
                            wr_idx               = vict_idx_reg;
                            rsp_next.evicted     = 1'b1;
                            rsp_next.evicted_key = vict_key_reg;
                        end
                        else
                        begin
                            wr_idx    = free_idx_reg;
                            live_next = live_reg + LIVE_W'(1);
                        end
                        valid_next[wr_idx] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            rd_on_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            vict_reg     <= 1'b0;
            free_reg     <= 1'b0;
            live_reg     <= '0;
            clock_reg    <= '0;
            cap_reg      <= CAP_RESET;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_on_reg    <= rd_on_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            vict_reg     <= vict_next;
            free_reg     <= free_next;
            live_reg     <= live_next;
            clock_reg    <= clock_next;
            cap_reg      <= cap_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        req_reg         <= req_next;
        found_idx_reg   <= found_idx_next;
        found_value_reg <= found_value_next;
        found_count_reg <= found_count_next;
        vict_idx_reg    <= vict_idx_next;
        vict_key_reg    <= vict_key_next;
        best_count_reg  <= best_count_next;
        best_stamp_reg  <= best_stamp_next;
        free_idx_reg    <= free_idx_next;
        rsp_reg         <= rsp_next;
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_key_en)
            begin
                slot_key_mem[wr_idx] <= wr_key;
            end
            if (wr_value_en)
            begin
                slot_value_mem[wr_idx] <= wr_value;
            end
            slot_count_mem[wr_idx] <= wr_count;
            slot_stamp_mem[wr_idx] <= wr_stamp;
        end
        rd_key_reg   <= slot_key_mem[idx_reg];
        rd_value_reg <= slot_value_mem[idx_reg];
        rd_count_reg <= slot_count_mem[idx_reg];
        rd_stamp_reg <= slot_stamp_mem[idx_reg];
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTH
    // entry count tracks the valid bits
    a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(live_reg))
        else $error("entry count differs from valid bits");

    // a result only follows the update step
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without update");

    // an eviction is never a hit
    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.evicted) |-> !rsp.hit)
        else $error("eviction reported on a hit");

    // an accepted request starts the scan at slot zero
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("scan did not start at slot zero");
`endif

endmodule
